// ----- hdl/tccw_pkg.sv -----
// Package for the text console cursor writer.
// Holds the field widths, grid defaults, control characters and the result type.
// Depends on nothing.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int GRID_WIDTH_DEF  = 80;
  localparam int GRID_HEIGHT_DEF = 25;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int IDX_W   = 11;
  localparam int PROD_W  = ROW_W + COL_W;

  localparam logic [CHAR_W-1:0]  CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0]  CH_BS       = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_NL       = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

  typedef struct packed {
    logic               write_valid;
    logic [IDX_W-1:0]   cell_index;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
  } tccw_result_t;

endpackage

// ----- hdl/tccw_cursor.sv -----
// Cursor state and per-character update for the text console cursor writer.
// Computes the cell write and the new cursor; depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_cursor import tccw_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [COLOR_W-1:0] text_color,
  output tccw_result_t       res
);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [COL_W:0]   WIDTH_K  = (COL_W + 1)'(GRID_WIDTH);

  logic [ROW_W-1:0] row_r, row_nxt, row_inc, wr_row;
  logic [COL_W-1:0] col_r, col_nxt, wr_col;
  logic [PROD_W-1:0] idx_full;
  logic             is_bs, is_nl, is_nul;

  assign is_nul  = (char_code == CH_NUL);
  assign is_bs   = (char_code == CH_BS);
  assign is_nl   = (char_code == CH_NL);
  assign row_inc = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    wr_row  = row_r;
    wr_col  = col_r;
    priority if (is_bs) begin
      if (col_r != '0) begin
        col_nxt = col_r - 1'b1;
      end else if (row_r != '0) begin
        row_nxt = row_r - 1'b1;
        col_nxt = COL_LAST;
      end
      wr_row = row_nxt;
      wr_col = col_nxt;
    end else if (is_nl) begin
      row_nxt = row_inc;
      col_nxt = '0;
    end else begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign idx_full = PROD_W'(wr_row * WIDTH_K) + PROD_W'(wr_col);

  always_comb begin
    res.write_valid = !is_nl;
    res.cell_index  = is_nl ? '0 : idx_full[IDX_W-1:0];
    res.cell_char   = is_nl ? '0 : (is_bs ? CH_SPACE : char_code);
    res.cell_color  = is_nl ? '0 : text_color;
    res.cursor_row  = row_nxt;
    res.cursor_col  = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (step_en && !is_nul) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_LAST)
    else $error("cursor row left the grid");

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("cursor column left the grid");

  a_nl_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && is_nl |=> col_r == '0)
    else $error("newline did not return the cursor to column zero");

  a_nul_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && is_nul |=> $stable(row_r) && $stable(col_r))
    else $error("NUL character moved the cursor");

endmodule

// ----- hdl/text_console_cursor_writer_top.sv -----
// Top level of the text console cursor writer.
// Input register, cursor unit, result register and color register; uses tccw_pkg, tccw_cursor.
// An accepted character is held in the input register, then its result in the result register.
// Throughput: one character per cycle while not stalled; NULs are dropped without a result.
// The cursor update and the row times width product sit between the input and result registers.
// Reset clears the cursor to row 0, column 0, empties both stages and sets the color to 7.
`timescale 1ns / 1ps

module text_console_cursor_writer_top import tccw_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_valid,
  output logic [IDX_W-1:0]   out_cell_index,
  output logic [CHAR_W-1:0]  out_cell_char,
  output logic [COLOR_W-1:0] out_cell_color,
  output logic [ROW_W-1:0]   out_cursor_row,
  output logic [COL_W-1:0]   out_cursor_col,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0]  s1_char_r;
  logic               out_valid_r, out_valid_nxt;
  tccw_result_t       out_r, step_res;
  logic [COLOR_W-1:0] color_r;
  logic               s1_move, s1_nul, in_acc;

  assign s1_nul   = (s1_char_r == CH_NUL);
  assign s1_move  = s1_valid_r && (s1_nul || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  tccw_cursor #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_move),
    .char_code  (s1_char_r),
    .text_color (color_r),
    .res        (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move && !s1_nul) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      color_r     <= COLOR_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_code;
    end
    if (s1_move && !s1_nul) begin
      out_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_valid = out_r.write_valid;
  assign out_cell_index  = out_r.cell_index;
  assign out_cell_char   = out_r.cell_char;
  assign out_cell_color  = out_r.cell_color;
  assign out_cursor_row  = out_r.cursor_row;
  assign out_cursor_col  = out_r.cursor_col;

endmodule

// ----- dv/text_console_cursor_writer_top_test.sv -----
// Self-checking testbench for text_console_cursor_writer_top with the default 80 x 25 grid.
// Drives character transactions with random idling and stalls, and checks every result
// against a cursor model kept here. Depends on tccw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module text_console_cursor_writer_top_test;
  import tccw_pkg::*;

  localparam int WIDTH = GRID_WIDTH_DEF;
  localparam int HEIGHT = GRID_HEIGHT_DEF;
  localparam int GAP_MAX = 19;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int CHARS_PER_PHASE = 170;
  localparam int PHASES = 5;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [CHAR_W-1:0] code;
    bit typed;
    tccw_result_t want;
  } opening_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_write_valid;
  logic [IDX_W-1:0] out_cell_index;
  logic [CHAR_W-1:0] out_cell_char;
  logic [COLOR_W-1:0] out_cell_color;
  logic [ROW_W-1:0] out_cursor_row;
  logic [COL_W-1:0] out_cursor_col;
  logic cfg_wr_en = 1'b0;
  logic [COLOR_W-1:0] cfg_wr_data = '0;

  int cur_row;
  int cur_col;
  logic [COLOR_W-1:0] cur_color;

  tccw_result_t cell_writes_due[$];
  opening_step_t opening_steps[$];

  int chars_sent = 0;
  int nuls_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int color_writes = 0;
  int idle_cycles = 0;
  int in_draws = 0;
  int out_draws = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  text_console_cursor_writer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_valid(out_write_valid),
    .out_cell_index(out_cell_index),
    .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function bit advance_cursor(input logic [CHAR_W-1:0] code, output tccw_result_t res);
    res = '0;
    if (code == CH_NUL) return 1'b0;
    if (code == CH_BS) begin
      if (cur_col > 0) begin
        cur_col = cur_col - 1;
      end else if (cur_row > 0) begin
        cur_row = cur_row - 1;
        cur_col = WIDTH - 1;
      end
      res.write_valid = 1'b1;
      res.cell_index = IDX_W'(cur_row * WIDTH + cur_col);
      res.cell_char = CH_SPACE;
      res.cell_color = cur_color;
    end else if (code == CH_NL) begin
      cur_row = (cur_row + 1 == HEIGHT) ? 0 : cur_row + 1;
      cur_col = 0;
    end else begin
      res.write_valid = 1'b1;
      res.cell_index = IDX_W'(cur_row * WIDTH + cur_col);
      res.cell_char = code;
      res.cell_color = cur_color;
      cur_col = cur_col + 1;
      if (cur_col == WIDTH) begin
        cur_col = 0;
        cur_row = (cur_row + 1 == HEIGHT) ? 0 : cur_row + 1;
      end
    end
    res.cursor_row = ROW_W'(cur_row);
    res.cursor_col = COL_W'(cur_col);
    return 1'b1;
  endfunction

  function tccw_result_t cell_result(input logic wv, input int idx, input logic [CHAR_W-1:0] ch,
                                     input logic [COLOR_W-1:0] color, input int row,
                                     input int col);
    tccw_result_t res;
    res.write_valid = wv;
    res.cell_index = IDX_W'(idx);
    res.cell_char = ch;
    res.cell_color = color;
    res.cursor_row = ROW_W'(row);
    res.cursor_col = COL_W'(col);
    return res;
  endfunction

  function logic [CHAR_W-1:0] random_printable();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_BS || c == CH_NL);
    return c;
  endfunction

  task automatic add_step(input logic [CHAR_W-1:0] code, input bit typed,
                          input tccw_result_t want);
    opening_step_t s;
    s.code = code;
    s.typed = typed;
    s.want = want;
    opening_steps.push_back(s);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] code, input bit typed,
                           input tccw_result_t want);
    int gap;
    bit makes_result;
    tccw_result_t predicted;
    gap = in_quiet ? 0 : $urandom_range(0, GAP_MAX);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (in_stall);
    makes_result = advance_cursor(code, predicted);
    if (makes_result) cell_writes_due.push_back(typed ? want : predicted);
    if (code == CH_NUL) nuls_sent++;
    else chars_sent++;
    in_draws++;
    if (in_draws == 40) begin
      in_draws = 0;
      in_quiet = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_any(input logic [CHAR_W-1:0] code);
    send_char(code, 1'b0, '0);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cell_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_color(input logic [COLOR_W-1:0] color);
    drain_and_settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= color;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_color = color;
    color_writes++;
  endtask

  // Walks the cursor down to the last row and fills it, so the last cell and both wraps occur.
  task automatic fill_last_row();
    while (cur_row != HEIGHT - 1) send_any(CH_NL);
    repeat (WIDTH + 1) send_any(random_printable());
  endtask

  task automatic random_burst();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
      repeat (len) send_any(($urandom_range(0, 11) == 0) ? CH_BS : random_printable());
      send_any(CH_NL);
    end else if (r < 80) begin
      repeat ($urandom_range(1, 6)) send_any(CH_BS);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 8)) send_any(CHAR_W'($urandom_range(0, 255)));
    end else if (r < 95) begin
      repeat ($urandom_range(1, 3)) send_any(CH_NUL);
    end else begin
      repeat ($urandom_range(1, 5)) send_any(CH_NL);
    end
  endtask

  task automatic report_mismatch(input string what, input tccw_result_t want,
                                 input tccw_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected wv=%0d idx=%0d ch=%02h col=%02h row=%0d cur=%0d",
               $realtime, what, want.write_valid, want.cell_index, want.cell_char,
               want.cell_color, want.cursor_row, want.cursor_col);
      $display("    got wv=%0d idx=%0d ch=%02h col=%02h row=%0d cur=%0d",
               got.write_valid, got.cell_index, got.cell_char, got.cell_color,
               got.cursor_row, got.cursor_col);
    end
  endtask

  always @(posedge clk) begin : check_results
    tccw_result_t got;
    tccw_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.write_valid = out_write_valid;
      got.cell_index = out_cell_index;
      got.cell_char = out_cell_char;
      got.cell_color = out_cell_color;
      got.cursor_row = out_cursor_row;
      got.cursor_col = out_cursor_col;
      if (cell_writes_due.size() == 0) begin
        report_mismatch("result with none pending", '0, got);
      end else begin
        want = cell_writes_due.pop_front();
        results_checked++;
        if (got.write_valid !== want.write_valid || got.cell_index !== want.cell_index ||
            got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
            got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
        $display("** text_console_cursor_writer_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int hold;
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      out_draws++;
      if (out_draws == 32) begin
        out_draws = 0;
        out_quiet = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    cur_row = 0;
    cur_col = 0;
    cur_color = COLOR_RESET;

    add_step(CH_BS, 1'b1, cell_result(1'b1, 0, CH_SPACE, COLOR_RESET, 0, 0));
    add_step(CH_NUL, 1'b0, '0);
    add_step(8'h41, 1'b1, cell_result(1'b1, 0, 8'h41, COLOR_RESET, 0, 1));
    add_step(CH_NL, 1'b1, cell_result(1'b0, 0, 8'h00, 8'h00, 1, 0));
    add_step(CH_BS, 1'b1, cell_result(1'b1, WIDTH - 1, CH_SPACE, COLOR_RESET, 0, WIDTH - 1));
    add_step(8'hFF, 1'b1, cell_result(1'b1, WIDTH - 1, 8'hFF, COLOR_RESET, 1, 0));
    add_step(8'h01, 1'b0, '0);
    add_step(8'h07, 1'b0, '0);
    add_step(CH_NUL, 1'b0, '0);
    add_step(8'h09, 1'b0, '0);
    add_step(8'h0B, 1'b0, '0);
    add_step(CH_SPACE, 1'b0, '0);
    add_step(8'h7F, 1'b0, '0);
    add_step(8'h80, 1'b0, '0);
    add_step(CH_BS, 1'b0, '0);
    add_step(CH_BS, 1'b0, '0);
    add_step(CH_NL, 1'b0, '0);
    add_step(CH_BS, 1'b0, '0);
    add_step(8'hFE, 1'b0, '0);
    add_step(CH_NUL, 1'b0, '0);
    add_step(8'h55, 1'b0, '0);
    add_step(8'hAA, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_steps[i]) begin
      send_char(opening_steps[i].code, opening_steps[i].typed, opening_steps[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_color(8'h00);
        1: set_color(8'hFF);
        default: set_color(COLOR_W'($urandom_range(0, 255)));
      endcase
      phase_start = chars_sent;
      if (phase % 2 == 0) fill_last_row();
      while (chars_sent - phase_start < CHARS_PER_PHASE) random_burst();
    end

    drain_and_settle();
    repeat (6) @(posedge clk);

    $display("Sent %0d characters and %0d NULs under %0d color writes; checked %0d results.",
             chars_sent, nuls_sent, color_writes, results_checked);
    $display("Covered backspace at both grid origins, column and row wrap, and %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** text_console_cursor_writer_top: PASSED **");
    end else begin
      $display("** text_console_cursor_writer_top: FAILED **");
    end
    $finish;
  end

endmodule
